>>> rtl/tcs_pkg.sv
package tcs_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int THR_WIDTH = 31;
  localparam logic [THR_WIDTH-1:0] THR_RESET = {THR_WIDTH{1'b1}};

  // Quotient bits resolved per divider stage.
  localparam int DIV_CHUNK = 8;

  localparam int NUM_SPLIT = 6;
  localparam int CNT_WIDTH = 3;
  localparam logic [CNT_WIDTH-1:0] LAST_TRI = CNT_WIDTH'(NUM_SPLIT - 1);

  typedef struct packed {
    logic valid;
    logic split;
  } split_ctl_t;

  // Long division by three over one chunk, most significant bit first.
  // Returns {remainder, quotient chunk}.
  function automatic logic [DIV_CHUNK+1:0] div3_chunk(input logic [1:0] r_in,
                                                      input logic [DIV_CHUNK-1:0] d);
    logic [2:0] t;
    logic [1:0] r;
    logic [DIV_CHUNK-1:0] q;
    r = r_in;
    q = '0;
    for (int i = DIV_CHUNK - 1; i >= 0; i--) begin
      t = {r, d[i]};
      if (t >= 3'd3) begin
        q[i] = 1'b1;
        t = t - 3'd3;
      end
      r = t[1:0];
    end
    return {r, q};
  endfunction

endpackage

>>> rtl/triangle_centroid_subdivider.sv
// Subdivides signed fixed-point triangles. A request is taken when start is high and busy is
// low; each result triangle appears on the out_ ports for one cycle with out_valid high, and
// out_last_in_run marks the final triangle of a request. The receiver cannot stall the block.
// A request yields one triangle (copied through) or six (split around the centroid and edge
// midpoints), one triangle per cycle; the single triangle emitter sets the throughput, and
// busy stays high while it works through a split, so an unsplit request does not hold off
// the next one. From acceptance to the first result a request passes an input register, a
// sum stage, a divide-by-three pipeline of eight quotient bits per stage, the threshold
// compare, the emitter and the output register; the stages ahead of the emitter hold while
// busy is high. The threshold is written with cfg_we and should change only while idle.
module triangle_centroid_subdivider #(
  parameter int COORD_WIDTH = tcs_pkg::COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tcs_pkg::THR_WIDTH-1:0] cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_v0_x,
  input  logic signed [COORD_WIDTH-1:0] in_v0_y,
  input  logic signed [COORD_WIDTH-1:0] in_v1_x,
  input  logic signed [COORD_WIDTH-1:0] in_v1_y,
  input  logic signed [COORD_WIDTH-1:0] in_v2_x,
  input  logic signed [COORD_WIDTH-1:0] in_v2_y,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_p0_x,
  output logic signed [COORD_WIDTH-1:0] out_p0_y,
  output logic signed [COORD_WIDTH-1:0] out_p1_x,
  output logic signed [COORD_WIDTH-1:0] out_p1_y,
  output logic signed [COORD_WIDTH-1:0] out_p2_x,
  output logic signed [COORD_WIDTH-1:0] out_p2_y,
  output logic                          out_last_in_run
);

  localparam int W   = COORD_WIDTH;
  localparam int CH  = tcs_pkg::DIV_CHUNK;
  localparam int ND  = (W + 2 + CH - 1) / CH;
  localparam int NBP = ND * CH;
  localparam int SW  = 12 * W;

  logic [tcs_pkg::THR_WIDTH-1:0] thr_r;
  logic                          adv;

  logic           d_vld  [ND+1];
  logic [NBP-1:0] d_wx   [ND+1];
  logic [NBP-1:0] d_wy   [ND+1];
  logic [1:0]     d_rx   [ND+1];
  logic [1:0]     d_ry   [ND+1];
  logic [SW-1:0]  d_side [ND+1];

  tcs_pkg::split_ctl_t s_ctl;
  logic [W-1:0]        s_cx, s_cy;
  logic [SW-1:0]       s_side;
  logic [W-1:0]        o_p0_x, o_p0_y, o_p1_x, o_p1_y, o_p2_x, o_p2_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= tcs_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // The whole pipeline moves together whenever the emitter can take its next request.
  assign busy = !adv;

  tcs_front #(.W(W), .NBP(NBP), .SW(SW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .start    (start),
    .in_v0_x  (in_v0_x),
    .in_v0_y  (in_v0_y),
    .in_v1_x  (in_v1_x),
    .in_v1_y  (in_v1_y),
    .in_v2_x  (in_v2_x),
    .in_v2_y  (in_v2_y),
    .out_vld  (d_vld[0]),
    .out_wx   (d_wx[0]),
    .out_wy   (d_wy[0]),
    .out_side (d_side[0])
  );

  assign d_rx[0] = 2'd0;
  assign d_ry[0] = 2'd0;

  for (genvar s = 0; s < ND; s++) begin : g_div
    tcs_div3_stage #(.NBP(NBP), .LO(NBP - CH * (s + 1)), .SW(SW)) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (d_vld[s]),
      .in_wx    (d_wx[s]),
      .in_wy    (d_wy[s]),
      .in_rx    (d_rx[s]),
      .in_ry    (d_ry[s]),
      .in_side  (d_side[s]),
      .out_vld  (d_vld[s+1]),
      .out_wx   (d_wx[s+1]),
      .out_wy   (d_wy[s+1]),
      .out_rx   (d_rx[s+1]),
      .out_ry   (d_ry[s+1]),
      .out_side (d_side[s+1])
    );
  end

  tcs_split #(.W(W), .SW(SW)) u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (d_vld[ND]),
    .in_qx    (d_wx[ND][W-1:0]),
    .in_qy    (d_wy[ND][W-1:0]),
    .in_side  (d_side[ND]),
    .thr      (thr_r),
    .out_ctl  (s_ctl),
    .out_cx   (s_cx),
    .out_cy   (s_cy),
    .out_side (s_side)
  );

  tcs_expand #(.W(W), .SW(SW)) u_expand (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ctl          (s_ctl),
    .in_cx           (s_cx),
    .in_cy           (s_cy),
    .in_side         (s_side),
    .free            (adv),
    .out_valid       (out_valid),
    .out_p0_x        (o_p0_x),
    .out_p0_y        (o_p0_y),
    .out_p1_x        (o_p1_x),
    .out_p1_y        (o_p1_y),
    .out_p2_x        (o_p2_x),
    .out_p2_y        (o_p2_y),
    .out_last_in_run (out_last_in_run)
  );

  assign out_p0_x = $signed(o_p0_x);
  assign out_p0_y = $signed(o_p0_y);
  assign out_p1_x = $signed(o_p1_x);
  assign out_p1_y = $signed(o_p1_y);
  assign out_p2_x = $signed(o_p2_x);
  assign out_p2_y = $signed(o_p2_y);

endmodule

>>> rtl/tcs_front.sv
module tcs_front #(
  parameter int W = tcs_pkg::COORD_WIDTH,
  parameter int NBP = 40,
  parameter int SW = 12 * tcs_pkg::COORD_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                start,
  input  logic signed [W-1:0] in_v0_x,
  input  logic signed [W-1:0] in_v0_y,
  input  logic signed [W-1:0] in_v1_x,
  input  logic signed [W-1:0] in_v1_y,
  input  logic signed [W-1:0] in_v2_x,
  input  logic signed [W-1:0] in_v2_y,
  output logic                out_vld,
  output logic [NBP-1:0]      out_wx,
  output logic [NBP-1:0]      out_wy,
  output logic [SW-1:0]       out_side
);

  // Adding 3 * 2^(W-1) makes the three-term sum non-negative; the divider
  // then works unsigned and the bias comes back out as one flipped bit.
  localparam logic [W+1:0] OFFSET = {1'b0, 2'b11, {(W-1){1'b0}}};

  logic                a_valid_r;
  logic signed [W-1:0] a_x_r [3];
  logic signed [W-1:0] a_y_r [3];

  logic                b_valid_r;
  logic [NBP-1:0]      b_wx_r;
  logic [NBP-1:0]      b_wy_r;
  logic [SW-1:0]       b_side_r;

  logic signed [W+1:0] sx, sy;
  logic [W+1:0]        ux, uy;
  logic signed [W:0]   tx [3];
  logic signed [W:0]   ty [3];
  logic [W-1:0]        mx [3];
  logic [W-1:0]        my [3];
  logic [SW-1:0]       side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= start;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x_r[0] <= in_v0_x;
      a_y_r[0] <= in_v0_y;
      a_x_r[1] <= in_v1_x;
      a_y_r[1] <= in_v1_y;
      a_x_r[2] <= in_v2_x;
      a_y_r[2] <= in_v2_y;
      b_wx_r   <= NBP'(ux);
      b_wy_r   <= NBP'(uy);
      b_side_r <= side_nxt;
    end
  end

  always_comb begin
    sx = (W+2)'(a_x_r[0]) + (W+2)'(a_x_r[1]) + (W+2)'(a_x_r[2]);
    sy = (W+2)'(a_y_r[0]) + (W+2)'(a_y_r[1]) + (W+2)'(a_y_r[2]);
    ux = $unsigned(sx) + OFFSET;
    uy = $unsigned(sy) + OFFSET;
    for (int i = 0; i < 3; i++) begin
      tx[i] = (W+1)'(a_x_r[i]) + (W+1)'(a_x_r[(i+1)%3]);
      ty[i] = (W+1)'(a_y_r[i]) + (W+1)'(a_y_r[(i+1)%3]);
      mx[i] = tx[i][W:1];
      my[i] = ty[i][W:1];
    end
    side_nxt = {my[2], mx[2], my[1], mx[1], my[0], mx[0],
                a_y_r[2], a_x_r[2], a_y_r[1], a_x_r[1], a_y_r[0], a_x_r[0]};
  end

  assign out_vld  = b_valid_r;
  assign out_wx   = b_wx_r;
  assign out_wy   = b_wy_r;
  assign out_side = b_side_r;

endmodule

>>> rtl/tcs_div3_stage.sv
module tcs_div3_stage #(
  parameter int NBP = 40,
  parameter int LO = 0,
  parameter int SW = 12 * tcs_pkg::COORD_WIDTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  logic [NBP-1:0] in_wx,
  input  logic [NBP-1:0] in_wy,
  input  logic [1:0]     in_rx,
  input  logic [1:0]     in_ry,
  input  logic [SW-1:0]  in_side,
  output logic           out_vld,
  output logic [NBP-1:0] out_wx,
  output logic [NBP-1:0] out_wy,
  output logic [1:0]     out_rx,
  output logic [1:0]     out_ry,
  output logic [SW-1:0]  out_side
);

  localparam int CH = tcs_pkg::DIV_CHUNK;

  logic           vld_r;
  logic [NBP-1:0] wx_r, wy_r;
  logic [1:0]     rx_r, ry_r;
  logic [SW-1:0]  side_r;

  logic [CH+1:0]  resx, resy;
  logic [NBP-1:0] wx_nxt, wy_nxt;

  // Bits above the chunk already hold quotient, bits below still hold the
  // dividend; this stage replaces its own chunk with quotient bits.
  always_comb begin
    resx = tcs_pkg::div3_chunk(in_rx, in_wx[LO +: CH]);
    resy = tcs_pkg::div3_chunk(in_ry, in_wy[LO +: CH]);
    wx_nxt = in_wx;
    wy_nxt = in_wy;
    wx_nxt[LO +: CH] = resx[CH-1:0];
    wy_nxt[LO +: CH] = resy[CH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wx_r   <= wx_nxt;
      wy_r   <= wy_nxt;
      rx_r   <= resx[CH+1:CH];
      ry_r   <= resy[CH+1:CH];
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_wx   = wx_r;
  assign out_wy   = wy_r;
  assign out_rx   = rx_r;
  assign out_ry   = ry_r;
  assign out_side = side_r;

endmodule

>>> rtl/tcs_split.sv
module tcs_split #(
  parameter int W = tcs_pkg::COORD_WIDTH,
  parameter int SW = 12 * tcs_pkg::COORD_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_vld,
  input  logic [W-1:0]                      in_qx,
  input  logic [W-1:0]                      in_qy,
  input  logic [SW-1:0]                     in_side,
  input  logic [tcs_pkg::THR_WIDTH-1:0]     thr,
  output tcs_pkg::split_ctl_t               out_ctl,
  output logic [W-1:0]                      out_cx,
  output logic [W-1:0]                      out_cy,
  output logic [SW-1:0]                     out_side
);

  localparam int DW = (W + 1 > tcs_pkg::THR_WIDTH) ? W + 1 : tcs_pkg::THR_WIDTH;

  tcs_pkg::split_ctl_t ctl_r;
  logic [W-1:0]        cx_r, cy_r;
  logic [SW-1:0]       side_r;

  logic [W-1:0]        cx, cy;
  logic signed [W:0]   ab [3];
  logic signed [W:0]   ba [3];
  logic [W:0]          mag [3];
  logic                split_nxt;

  always_comb begin
    // Removing the bias of 2^(W-1) from the quotient flips its top bit.
    cx = {~in_qx[W-1], in_qx[W-2:0]};
    cy = {~in_qy[W-1], in_qy[W-2:0]};
    split_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ab[i]  = (W+1)'($signed(in_side[2*i*W +: W])) - (W+1)'($signed(cx));
      ba[i]  = (W+1)'($signed(cx)) - (W+1)'($signed(in_side[2*i*W +: W]));
      mag[i] = ab[i][W] ? $unsigned(ba[i]) : $unsigned(ab[i]);
      if (DW'(mag[i]) > DW'(thr)) begin
        split_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r.valid <= in_vld;
      ctl_r.split <= split_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r   <= cx;
      cy_r   <= cy;
      side_r <= in_side;
    end
  end

  assign out_ctl  = ctl_r;
  assign out_cx   = cx_r;
  assign out_cy   = cy_r;
  assign out_side = side_r;

endmodule

>>> rtl/tcs_expand.sv
module tcs_expand #(
  parameter int W = tcs_pkg::COORD_WIDTH,
  parameter int SW = 12 * tcs_pkg::COORD_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcs_pkg::split_ctl_t in_ctl,
  input  logic [W-1:0]        in_cx,
  input  logic [W-1:0]        in_cy,
  input  logic [SW-1:0]       in_side,
  output logic                free,
  output logic                out_valid,
  output logic [W-1:0]        out_p0_x,
  output logic [W-1:0]        out_p0_y,
  output logic [W-1:0]        out_p1_x,
  output logic [W-1:0]        out_p1_y,
  output logic [W-1:0]        out_p2_x,
  output logic [W-1:0]        out_p2_y,
  output logic                out_last_in_run
);

  localparam int CW = tcs_pkg::CNT_WIDTH;

  logic          e_valid_r;
  logic          e_split_r;
  logic [CW-1:0] e_cnt_r;
  logic [W-1:0]  e_vx_r [3];
  logic [W-1:0]  e_vy_r [3];
  logic [W-1:0]  e_mx_r [3];
  logic [W-1:0]  e_my_r [3];
  logic [W-1:0]  e_cx_r, e_cy_r;

  logic          o_valid_r;
  logic          o_last_r;
  logic [W-1:0]  o_x_r [3];
  logic [W-1:0]  o_y_r [3];

  logic          e_last;
  logic [W-1:0]  sel_x [3];
  logic [W-1:0]  sel_y [3];

  always_comb begin
    e_last = !e_split_r || (e_cnt_r == tcs_pkg::LAST_TRI);
    free   = !e_valid_r || e_last;
  end

  // Split order per edge i: (m_i, centroid, v_i) then (m_i, v_i+1, centroid).
  always_comb begin
    sel_x[0] = e_vx_r[0]; sel_y[0] = e_vy_r[0];
    sel_x[1] = e_vx_r[1]; sel_y[1] = e_vy_r[1];
    sel_x[2] = e_vx_r[2]; sel_y[2] = e_vy_r[2];
    if (e_split_r) begin
      case (e_cnt_r)
        3'd0: begin
          sel_x = '{e_mx_r[0], e_cx_r, e_vx_r[0]};
          sel_y = '{e_my_r[0], e_cy_r, e_vy_r[0]};
        end
        3'd1: begin
          sel_x = '{e_mx_r[0], e_vx_r[1], e_cx_r};
          sel_y = '{e_my_r[0], e_vy_r[1], e_cy_r};
        end
        3'd2: begin
          sel_x = '{e_mx_r[1], e_cx_r, e_vx_r[1]};
          sel_y = '{e_my_r[1], e_cy_r, e_vy_r[1]};
        end
        3'd3: begin
          sel_x = '{e_mx_r[1], e_vx_r[2], e_cx_r};
          sel_y = '{e_my_r[1], e_vy_r[2], e_cy_r};
        end
        3'd4: begin
          sel_x = '{e_mx_r[2], e_cx_r, e_vx_r[2]};
          sel_y = '{e_my_r[2], e_cy_r, e_vy_r[2]};
        end
        default: begin
          sel_x = '{e_mx_r[2], e_vx_r[0], e_cx_r};
          sel_y = '{e_my_r[2], e_vy_r[0], e_cy_r};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      e_cnt_r   <= '0;
      o_valid_r <= 1'b0;
      o_last_r  <= 1'b0;
    end else begin
      if (free) begin
        e_valid_r <= in_ctl.valid;
        e_cnt_r   <= '0;
      end else begin
        e_cnt_r <= e_cnt_r + CW'(1);
      end
      o_valid_r <= e_valid_r;
      o_last_r  <= e_valid_r && e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (free && in_ctl.valid) begin
      e_split_r <= in_ctl.split;
      e_cx_r    <= in_cx;
      e_cy_r    <= in_cy;
      for (int i = 0; i < 3; i++) begin
        e_vx_r[i] <= in_side[(2*i)*W +: W];
        e_vy_r[i] <= in_side[(2*i+1)*W +: W];
        e_mx_r[i] <= in_side[(2*i+6)*W +: W];
        e_my_r[i] <= in_side[(2*i+7)*W +: W];
      end
    end
    for (int i = 0; i < 3; i++) begin
      o_x_r[i] <= sel_x[i];
      o_y_r[i] <= sel_y[i];
    end
  end

  assign out_valid       = o_valid_r;
  assign out_last_in_run = o_last_r;
  assign out_p0_x        = o_x_r[0];
  assign out_p0_y        = o_y_r[0];
  assign out_p1_x        = o_x_r[1];
  assign out_p1_y        = o_y_r[1];
  assign out_p2_x        = o_x_r[2];
  assign out_p2_y        = o_y_r[2];

  a_run_advances: assert property (@(posedge clk) disable iff (!rst_n)
    e_valid_r && !e_last |=> e_valid_r && (e_cnt_r == $past(e_cnt_r) + CW'(1)))
    else $error("split run did not advance to the next triangle");

  a_held_item_emits: assert property (@(posedge clk) disable iff (!rst_n)
    e_valid_r |=> o_valid_r)
    else $error("held request produced no result");

  a_unsplit_single: assert property (@(posedge clk) disable iff (!rst_n)
    e_valid_r && !e_split_r |-> e_cnt_r == '0)
    else $error("unsplit request counted past its only triangle");

  a_last_marks_result: assert property (@(posedge clk) disable iff (!rst_n)
    o_last_r |-> o_valid_r)
    else $error("last flag raised without a result");

endmodule
